### hw/rtl/hstsu_pkg.sv
// ----------------------------------------------------------------------------
// hstsu_pkg
// Shared types, constants and the quarter-wave sine table of the harmonic
// series tone sequencer.
// ----------------------------------------------------------------------------
package hstsu_pkg;

  localparam int HarmonicCount = 16;
  localparam int SineDepth     = 256;
  localparam logic [14:0] FullScale = 15'd32767;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [30:0] QuarterMax = 31'h7FFF_FFFF;

  // register byte addresses, bits [3:2]
  localparam logic [1:0] RegFundStep  = 2'd0;
  localparam logic [1:0] RegSeriesMode = 2'd1;
  localparam logic [1:0] RegNoteSamples = 2'd2;

  // Taylor divisors (2n)(2n+1) for n = 1..7
  localparam logic [7:0] TermDiv [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

  typedef logic [14:0] sine_rom_t [SineDepth];

  typedef enum logic [1:0] {
    DIV_STEP,
    DIV_QUARTER,
    DIV_TAIL
  } div_sel_e;

  typedef struct packed {
    logic     accept;
    logic     load_mul;
    logic     div_start;
    div_sel_e div_sel;
    logic     step_div;
    logic     q_sat;
    logic     q_div;
    logic     eval;
    logic     tstep_zero;
    logic     tstep_div;
    logic     tail;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic note_start;
    logic undertone;
    logic step_zero;
    logic div_done;
    logic fin;
    logic in_tail;
    logic tone_sample;
    logic qp_zero;
    logic out_free;
  } dp_status_t;

  // Build the table with a fixed Q30 Taylor series at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t           rom;
    logic [63:0]         x;
    logic [63:0]         term;
    logic [63:0]         v;
    logic signed [63:0]  sum;
    for (int i = 0; i < SineDepth; i++) begin
      x    = (HalfPiQ30 * 64'(i)) / SineDepth;
      term = x;
      sum  = signed'(x);
      for (int n = 0; n < 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'(TermDiv[n]);
        if ((n % 2) == 0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = (64'(sum) * 64'(FullScale) + 64'h2000_0000) >> 30;
      if (v > 64'(FullScale)) begin
        v = 64'(FullScale);
      end
      rom[i] = v[14:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

### hw/rtl/hstsu_div.sv
// ----------------------------------------------------------------------------
// hstsu_div
// Shared 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hstsu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, quo_q[31]};
    diff   = rem_sh - {1'b0, dvs_q};
    quo_d  = {quo_q[30:0], 1'b0};
    rem_d  = rem_sh[31:0];
    if (rem_sh >= {1'b0, dvs_q}) begin
      rem_d    = diff[31:0];
      quo_d[0] = 1'b1;
    end
  end

  // control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hw/rtl/hstsu_ctrl.sv
// ----------------------------------------------------------------------------
// hstsu_ctrl
// Sequencer: steps one tick through note load, sample, tail and output.
// ----------------------------------------------------------------------------
module hstsu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hstsu_pkg::dp_status_t  status_i,
  output hstsu_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_STEP,
    S_Q_START,
    S_DIV_Q,
    S_EVAL,
    S_DIV_T,
    S_TAIL,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  // decode commands and next state
  always_comb begin
    cmd_o      = '0;
    cmd_o.div_sel = hstsu_pkg::DIV_STEP;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status_i.note_start) begin
          state_d = S_EVAL;
        end else if (status_i.undertone) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = hstsu_pkg::DIV_STEP;
          state_d         = S_DIV_STEP;
        end else begin
          cmd_o.load_mul = 1'b1;
          state_d        = S_Q_START;
        end
      end
      S_DIV_STEP: begin
        if (status_i.div_done) begin
          cmd_o.step_div = 1'b1;
          state_d        = S_Q_START;
        end
      end
      S_Q_START: begin
        if (status_i.step_zero) begin
          cmd_o.q_sat = 1'b1;
          state_d     = S_EVAL;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = hstsu_pkg::DIV_QUARTER;
          state_d         = S_DIV_Q;
        end
      end
      S_DIV_Q: begin
        if (status_i.div_done) begin
          cmd_o.q_div = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.fin || (!status_i.in_tail && status_i.tone_sample)) begin
          state_d = S_OUT;
        end else if (status_i.in_tail) begin
          state_d = S_TAIL;
        end else if (status_i.qp_zero) begin
          cmd_o.tstep_zero = 1'b1;
          state_d          = S_TAIL;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = hstsu_pkg::DIV_TAIL;
          state_d         = S_DIV_T;
        end
      end
      S_DIV_T: begin
        if (status_i.div_done) begin
          cmd_o.tstep_div = 1'b1;
          state_d         = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/hstsu_dp.sv
// ----------------------------------------------------------------------------
// hstsu_dp
// Datapath: note state, phase accumulator, sine lookup, tail ramp, output.
// ----------------------------------------------------------------------------
module hstsu_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hstsu_pkg::ctrl_cmd_t  cmd_i,
  output hstsu_pkg::dp_status_t status_o,
  input  logic                  restart_i,
  input  logic [30:0]           fund_step_i,
  input  logic                  series_mode_i,
  input  logic [23:0]           note_samples_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           out_sample_o,
  output logic [4:0]            out_harm_o,
  output logic                  out_dec_o,
  output logic                  out_done_o
);

  logic [31:0] phase_q;
  logic [4:0]  harm_q;
  logic [31:0] step_q;
  logic [31:0] cnt_q;
  logic [30:0] qp_q;
  logic        tail_q;
  logic [15:0] level_q;
  logic [15:0] tstep_q;
  logic        fin_q;

  logic [15:0] res_sample_q;
  logic [4:0]  res_harm_q;
  logic        res_dec_q;
  logic        res_done_q;

  logic        out_valid_q;
  logic [15:0] out_sample_q;
  logic [4:0]  out_harm_q;
  logic        out_dec_q;
  logic        out_done_q;

  logic [35:0] mul_full;
  logic [23:0] tone;
  logic [1:0]  quad;
  logic [7:0]  idx;
  logic [7:0]  idx_m;
  logic [14:0] mag;
  logic [15:0] sine;
  logic [14:0] sine_abs;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic        div_done;
  logic [31:0] div_quo;

  // overtone step and tone length
  assign mul_full = 36'(fund_step_i) * 36'(harm_q);
  assign tone     = ({9'd0, note_samples_i} > {2'b0, qp_q}) ?
                    24'({9'd0, note_samples_i} - {2'b0, qp_q}) : 24'd0;

  // quarter-wave lookup with mirror and sign
  always_comb begin
    quad  = phase_q[31:30];
    idx   = phase_q[29:22];
    idx_m = ~idx + 8'd1;
    if (quad[0]) begin
      mag = (idx == 8'd0) ? hstsu_pkg::FullScale : hstsu_pkg::SineRom[idx_m];
    end else begin
      mag = hstsu_pkg::SineRom[idx];
    end
    sine     = quad[1] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    sine_abs = mag;
  end

  // divider operand select
  always_comb begin
    case (cmd_i.div_sel)
      hstsu_pkg::DIV_STEP: begin
        div_a = {1'b0, fund_step_i};
        div_b = {27'd0, harm_q};
      end
      hstsu_pkg::DIV_QUARTER: begin
        div_a = 32'h4000_0000;
        div_b = step_q;
      end
      hstsu_pkg::DIV_TAIL: begin
        div_a = {17'd0, sine_abs};
        div_b = {1'b0, qp_q};
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  hstsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // status back to the sequencer
  always_comb begin
    status_o.note_start  = !fin_q && !tail_q && (cnt_q == 32'd0);
    status_o.undertone   = series_mode_i;
    status_o.step_zero   = (step_q == 32'd0);
    status_o.div_done    = div_done;
    status_o.fin         = fin_q;
    status_o.in_tail     = tail_q;
    status_o.tone_sample = (cnt_q < {8'd0, tone});
    status_o.qp_zero     = (qp_q == 31'd0);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  // control state of the series
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      harm_q  <= 5'd1;
      step_q  <= '0;
      cnt_q   <= '0;
      qp_q    <= '0;
      tail_q  <= 1'b0;
      level_q <= '0;
      tstep_q <= '0;
      fin_q   <= 1'b0;
    end else begin
      if (cmd_i.accept && restart_i) begin
        harm_q <= 5'd1;
        cnt_q  <= '0;
        tail_q <= 1'b0;
        fin_q  <= 1'b0;
      end
      if (cmd_i.load_mul) begin
        step_q  <= mul_full[31:0];
        phase_q <= '0;
      end
      if (cmd_i.step_div) begin
        step_q  <= div_quo;
        phase_q <= '0;
      end
      if (cmd_i.q_sat) begin
        qp_q <= hstsu_pkg::QuarterMax;
      end
      if (cmd_i.q_div) begin
        qp_q <= div_quo[30:0];
      end
      // tone sample or entry into the tail
      if (cmd_i.eval && !fin_q && !tail_q) begin
        phase_q <= phase_q + step_q;
        if (status_o.tone_sample) begin
          cnt_q <= cnt_q + 32'd1;
        end else begin
          level_q <= sine;
          tail_q  <= 1'b1;
          cnt_q   <= '0;
        end
      end
      if (cmd_i.tstep_zero) begin
        tstep_q <= '0;
      end
      if (cmd_i.tstep_div) begin
        tstep_q <= level_q[15] ? (16'd0 - div_quo[15:0]) : div_quo[15:0];
      end
      // one ramp sample, close the note at its end
      if (cmd_i.tail) begin
        level_q <= level_q - tstep_q;
        if (cnt_q >= {1'b0, qp_q}) begin
          tail_q <= 1'b0;
          cnt_q  <= '0;
          harm_q <= harm_q + 5'd1;
          if (harm_q == 5'(hstsu_pkg::HarmonicCount)) begin
            fin_q <= 1'b1;
          end
        end else begin
          cnt_q <= cnt_q + 32'd1;
        end
      end
    end
  end

  // pending result of the current tick
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      res_harm_q   <= fin_q ? 5'd0 : harm_q;
      res_done_q   <= fin_q;
      res_dec_q    <= 1'b0;
      res_sample_q <= (!fin_q && !tail_q) ? sine : 16'd0;
    end
    if (cmd_i.tail) begin
      res_sample_q <= level_q;
      res_dec_q    <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sample_q <= res_sample_q;
      out_harm_q   <= res_harm_q;
      out_dec_q    <= res_dec_q;
      out_done_q   <= res_done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_harm_o   = out_harm_q;
  assign out_dec_o    = out_dec_q;
  assign out_done_o   = out_done_q;

endmodule

### hw/rtl/harmonic_series_tone_sequencer_unit.sv
// ----------------------------------------------------------------------------
// harmonic_series_tone_sequencer_unit
// Plays harmonics 1..16 of a fundamental (undertones in undertone mode) as sine notes with a linear release.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the s_axis channel is one sample tick; tdata[0] = 1 restarts
//   the series at harmonic one. Every tick returns exactly one beat on the
//   m_axis channel with the sample, harmonic number, decay flag and done flag.
//   The APB port holds fundamental step (0x0), series mode (0x4) and note
//   length in samples (0x8); write only while no tick is in flight.
// Sequencing:
//   One tick at a time; the next tick is taken once the sequencer returns to
//   idle after loading the output register. A tone sample passes check,
//   evaluation and output, a tail sample also the tail state. A note start
//   adds a pass of the shared divider for the quarter period, one more in
//   undertone mode for the step; the entry into the tail adds one for the
//   ramp step. These bit-serial divider passes set the worst case.
// Reset:
//   Registers return to their documented defaults; harmonic one is next.
// Stall:
//   A finished result waits in the output register while the next tick may
//   be accepted; the sequencer holds its last state until the register frees.
// ----------------------------------------------------------------------------
module harmonic_series_tone_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] sample, [20:16] harmonic,
                                      // [21] decaying, [22] series_done, [23] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [30:0] fund_step_q;
  logic        series_mode_q;
  logic [23:0] note_samples_q;
  logic        cfg_we;

  hstsu_pkg::ctrl_cmd_t  cmd;
  hstsu_pkg::dp_status_t status;

  logic [15:0] out_sample;
  logic [4:0]  out_harm;
  logic        out_dec;
  logic        out_done;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fund_step_q    <= 31'd39370534;
      series_mode_q  <= 1'b0;
      note_samples_q <= 24'd48000;
    end else if (cfg_we) begin
      case (paddr[3:2])
        hstsu_pkg::RegFundStep:    fund_step_q    <= pwdata[30:0];
        hstsu_pkg::RegSeriesMode:  series_mode_q  <= pwdata[0];
        hstsu_pkg::RegNoteSamples: note_samples_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      hstsu_pkg::RegFundStep:    prdata = {1'b0, fund_step_q};
      hstsu_pkg::RegSeriesMode:  prdata = {31'd0, series_mode_q};
      hstsu_pkg::RegNoteSamples: prdata = {8'd0, note_samples_q};
      default:                   prdata = '0;
    endcase
  end

  hstsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hstsu_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .restart_i      (s_axis_tdata[0]),
    .fund_step_i    (fund_step_q),
    .series_mode_i  (series_mode_q),
    .note_samples_i (note_samples_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_sample_o   (out_sample),
    .out_harm_o     (out_harm),
    .out_dec_o      (out_dec),
    .out_done_o     (out_done)
  );

  assign m_axis_tdata = {1'b0, out_done, out_dec, out_harm, out_sample};

`ifndef NO_ASSERTIONS
  a_done_no_harm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[22] |-> m_axis_tdata[20:16] == 5'd0 && !m_axis_tdata[21])
    else $error("series_done with a harmonic or decay flag set");

  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second tick accepted while one is in flight");

  a_harm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:16] <= 5'd16)
    else $error("harmonic number out of range");
`endif

endmodule
